// File: rtl/core/lzd_pkg.sv
// package for the lz77 token stream decompressor
// holds window sizing, parser and back-end state types and the queue command type
`default_nettype none

package lzd_pkg;

    // history depth, a power of two from 256 to 65536
    localparam int WINDOW_DEPTH = 65536;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int HELD_W       = PTR_W + 1;
    localparam int DIST_W       = 16;
    localparam int CMP_W        = DIST_W + 1;
    localparam int LEN_W        = 6;

    // command queue between parser and copy engine
    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_W    = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W    = CMD_PTR_W + 1;

    localparam logic [7:0] MATCH_SHORT_BASE = 8'd128;
    localparam logic [7:0] MATCH_LONG_BASE  = 8'd192;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_OFFSET_ONE,
        PH_OFFSET_HIGH,
        PH_OFFSET_LOW
    } parse_phase_t;

    typedef enum logic {
        BK_IDLE,
        BK_COPY
    } back_state_t;

    typedef enum logic {
        CMD_LITERAL,
        CMD_MATCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [7:0]            lit;
        logic [LEN_W-1:0]      len;
        logic [DIST_W-1:0]     offset;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/core/lzd_in_if.sv
// compressed byte channel: valid, ready and one stream byte
// no dependencies
`default_nettype none

interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
    modport monitor (input valid, input in_byte, input ready);
endinterface

`default_nettype wire

// File: rtl/core/lzd_out_if.sv
// decompressed byte channel: valid, ready, byte and run/error flags
// no dependencies
`default_nettype none

interface lzd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       bad_offset;

    modport source (output valid, output out_byte, output last_of_run, output bad_offset,
                    input ready);
    modport sink (input valid, input out_byte, input last_of_run, input bad_offset,
                  output ready);
    modport monitor (input valid, input out_byte, input last_of_run, input bad_offset,
                     input ready);
endinterface

`default_nettype wire

// File: rtl/core/lzd_front.sv
// token parser: turns compressed bytes into literal and match commands
// depends on lzd_pkg
`default_nettype none

module lzd_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            in_byte,
    output logic                       in_ready,
    input  wire lzd_pkg::queue_status_t q_status,
    output logic                       push,
    output lzd_pkg::cmd_t              push_cmd
);
    import lzd_pkg::*;

    parse_phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [7:0]             off_hi_reg, off_hi_next;
    logic                   accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next      = phase_reg;
        len_next        = len_reg;
        off_hi_next     = off_hi_reg;
        push            = 1'b0;
        push_cmd.kind   = CMD_LITERAL;
        push_cmd.lit    = in_byte;
        push_cmd.len    = len_reg;
        push_cmd.offset = DIST_W'(in_byte);
        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (in_byte < MATCH_SHORT_BASE)
                    begin
                        push = 1'b1;
                    end
                    else
                    begin
                        len_next   = in_byte[LEN_W-1:0];
                        phase_next = (in_byte < MATCH_LONG_BASE) ? PH_OFFSET_ONE
                                                                 : PH_OFFSET_HIGH;
                    end
                end
                PH_OFFSET_ONE:
                begin
                    // zero length match emits nothing, so drop it here
                    push          = (len_reg != '0);
                    push_cmd.kind = CMD_MATCH;
                    len_next      = '0;
                    phase_next    = PH_HEADER;
                end
                PH_OFFSET_HIGH:
                begin
                    off_hi_next = in_byte;
                    phase_next  = PH_OFFSET_LOW;
                end
                PH_OFFSET_LOW:
                begin
                    push            = (len_reg != '0);
                    push_cmd.kind   = CMD_MATCH;
                    push_cmd.offset = {off_hi_reg, in_byte};
                    len_next        = '0;
                    phase_next      = PH_HEADER;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            len_reg    <= '0;
            off_hi_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            off_hi_reg <= off_hi_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lzd_cmd_fifo.sv
// small command queue between parser and copy engine
// depends on lzd_pkg
`default_nettype none

module lzd_cmd_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire lzd_pkg::cmd_t          push_cmd,
    input  wire logic                   pop,
    output lzd_pkg::cmd_t               head_cmd,
    output lzd_pkg::queue_status_t      status
);
    import lzd_pkg::*;

    cmd_t                   entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign status.full  = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lzd_back.sv
// copy engine: history window, offset check and result register
// depends on lzd_pkg
`default_nettype none

module lzd_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lzd_pkg::cmd_t          head_cmd,
    input  wire lzd_pkg::queue_status_t q_status,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  out_byte,
    output logic                        out_last,
    output logic                        out_bad
);
    import lzd_pkg::*;

    logic [7:0]         hist_mem [WINDOW_DEPTH];
    logic [7:0]         rd_data_reg;

    back_state_t        state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [PTR_W-1:0]   dist_reg, dist_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [HELD_W-1:0]  held_reg, held_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;
    logic               out_bad_reg;

    logic               slot_free;
    logic               dist_bad;
    logic               lit_go, err_go, match_go, copy_go;
    logic               we, re;
    logic [7:0]         wdata;
    logic [PTR_W-1:0]   raddr;
    logic               load;
    logic [7:0]         ld_byte;
    logic               ld_last, ld_bad;

    assign slot_free = !out_valid_reg || out_ready;
    assign dist_bad  = (head_cmd.offset == '0)
                       || (CMP_W'(head_cmd.offset) > CMP_W'(held_reg));

    always_comb
    begin
        lit_go   = 1'b0;
        err_go   = 1'b0;
        match_go = 1'b0;
        copy_go  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (head_cmd.kind == CMD_LITERAL)
                    begin
                        lit_go = slot_free;
                    end
                    else if (dist_bad)
                    begin
                        err_go = slot_free;
                    end
                    else
                    begin
                        match_go = 1'b1;
                    end
                end
            end
            BK_COPY:
            begin
                copy_go = slot_free;
            end
            default:
            begin
                copy_go = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (match_go)
                begin
                    state_next = BK_COPY;
                end
            end
            BK_COPY:
            begin
                if (copy_go && len_reg == LEN_W'(1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop       = lit_go || err_go || match_go;
        len_next  = len_reg;
        dist_next = dist_reg;
        wp_next   = wp_reg;
        held_next = held_reg;
        we        = 1'b0;
        wdata     = head_cmd.lit;
        re        = 1'b0;
        raddr     = wp_reg - dist_reg;
        load      = 1'b0;
        ld_byte   = head_cmd.lit;
        ld_last   = 1'b1;
        ld_bad    = 1'b0;
        if (lit_go)
        begin
            we   = 1'b1;
            load = 1'b1;
        end
        else if (err_go)
        begin
            load    = 1'b1;
            ld_byte = '0;
            ld_bad  = 1'b1;
        end
        else if (match_go)
        begin
            len_next  = head_cmd.len;
            dist_next = head_cmd.offset[PTR_W-1:0];
            re        = 1'b1;
            raddr     = wp_reg - head_cmd.offset[PTR_W-1:0];
        end
        else if (copy_go)
        begin
            we       = 1'b1;
            wdata    = rd_data_reg;
            load     = 1'b1;
            ld_byte  = rd_data_reg;
            ld_last  = (len_reg == LEN_W'(1));
            len_next = len_reg - 1'b1;
            // fetch the next source byte while this one is written
            re       = (len_reg != LEN_W'(1));
            raddr    = wp_reg + 1'b1 - dist_reg;
        end
        if (we)
        begin
            wp_next = wp_reg + 1'b1;
            if (held_reg != HELD_W'(WINDOW_DEPTH))
            begin
                held_next = held_reg + 1'b1;
            end
        end
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            len_reg       <= '0;
            dist_reg      <= '0;
            wp_reg        <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            dist_reg      <= dist_next;
            wp_reg        <= wp_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // history window, read-during-write returns the new byte (offset one overlap)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[wp_reg] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= (we && raddr == wp_reg) ? wdata : hist_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= ld_byte;
            out_last_reg <= ld_last;
            out_bad_reg  <= ld_bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

endmodule

`default_nettype wire

// File: rtl/core/lz77_token_stream_decompressor_core.sv
// lz77 token stream decompressor: parser, command queue, copy engine
// latency: a literal result passes through the command queue and then the output result register
// throughput: the parser takes one header, offset or literal byte per cycle while the command
//   queue is not full; the copy engine starts a match with one history read, then writes one byte
//   a cycle while the output is not stalled; input stalls only when the four-entry command queue is full
// reset: asynchronous, clears parser, queue, pointers and output valid; history is not cleared
`default_nettype none

module lz77_token_stream_decompressor_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lzd_in_if.sink      compressed,
    lzd_out_if.source   decompressed
);
    import lzd_pkg::*;

    queue_status_t  q_status;
    logic           push;
    cmd_t           push_cmd;
    logic           pop;
    cmd_t           head_cmd;

    lzd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (compressed.valid),
        .in_byte  (compressed.in_byte),
        .in_ready (compressed.ready),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lzd_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    lzd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (decompressed.valid),
        .out_ready (decompressed.ready),
        .out_byte  (decompressed.out_byte),
        .out_last  (decompressed.last_of_run),
        .out_bad   (decompressed.bad_offset)
    );

endmodule

`default_nettype wire

// File: rtl/core/lzd_checker.sv
// port-level checks for the decompressor core, bound to the top level
// depends on the result channel signals of lz77_token_stream_decompressor_core
`default_nettype none

module lzd_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       out_last,
    input  wire logic       out_bad
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_bad))
        else $error("result changed while stalled");

    // an error result is a lone zero byte that ends the run
    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_bad |-> out_last && out_byte == 8'd0)
        else $error("malformed error result");

    // no result while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // nothing comes out in the cycle after reset releases
    a_first_quiet: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind lz77_token_stream_decompressor_core lzd_checker u_lzd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (decompressed.valid),
    .out_ready (decompressed.ready),
    .out_byte  (decompressed.out_byte),
    .out_last  (decompressed.last_of_run),
    .out_bad   (decompressed.bad_offset)
);

`default_nettype wire

// File: tb/lz77_token_stream_decompressor_core_tb.sv
// testbench for the lz77 token stream decompressor core: random and directed token streams
// checked byte by byte against an in-bench decoder with its own history window
// depends on lzd_pkg, lzd_in_if, lzd_out_if and the core module
`timescale 1ns / 100ps

module lz77_token_stream_decompressor_core_tb;

    import lzd_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 240;
    localparam int LONG_MATCHES = 10;
    localparam int TAIL_BYTES   = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } out_item_t;

    // decoder state mirrors the block; results are queued per accepted item
    class lzd_byte_scoreboard;
        logic [7:0]        hist [WINDOW_DEPTH];
        logic [PTR_W-1:0]  wr_ptr;
        logic [HELD_W-1:0] held;
        parse_phase_t      phase;
        logic [LEN_W-1:0]  pend_len;
        logic [7:0]        pend_hi;
        out_item_t         expected_bytes [$];
        int                errors;
        int                inputs;
        int                results;
        int                literals;
        int                copied;
        int                bad_runs;
        bit                wrapped;

        function new();
            wr_ptr   = '0;
            held     = '0;
            phase    = PH_HEADER;
            pend_len = '0;
            pend_hi  = '0;
            errors   = 0;
            inputs   = 0;
            results  = 0;
            literals = 0;
            copied   = 0;
            bad_runs = 0;
            wrapped  = 1'b0;
        endfunction

        function void push_hist(logic [7:0] b);
            hist[wr_ptr] = b;
            wr_ptr = wr_ptr + 1'b1;
            if (wr_ptr == '0)
                wrapped = 1'b1;
            if (held < WINDOW_DEPTH)
                held = held + 1'b1;
        endfunction

        function void expect_match(logic [LEN_W-1:0] len, logic [DIST_W-1:0] offset);
            logic [PTR_W-1:0] src;
            logic [7:0]       b;
            if (len == '0)
                return;
            if (offset == '0 || {1'b0, offset} > held)
            begin
                expected_bytes.push_back('{8'h00, 1'b1, 1'b1});
                bad_runs++;
                return;
            end
            for (int k = 0; k < len; k++)
            begin
                // source re-read after every push so overlapping copies repeat data
                src = wr_ptr - offset[PTR_W-1:0];
                b = hist[src];
                push_hist(b);
                expected_bytes.push_back('{b, (k + 1 == len), 1'b0});
            end
            copied += len;
        endfunction

        function void note_byte(logic [7:0] b);
            inputs++;
            case (phase)
                PH_HEADER:
                begin
                    if (b < MATCH_SHORT_BASE)
                    begin
                        push_hist(b);
                        expected_bytes.push_back('{b, 1'b1, 1'b0});
                        literals++;
                    end
                    else
                    begin
                        pend_len = b[LEN_W-1:0];
                        phase = (b < MATCH_LONG_BASE) ? PH_OFFSET_ONE : PH_OFFSET_HIGH;
                    end
                end
                PH_OFFSET_ONE:
                begin
                    phase = PH_HEADER;
                    expect_match(pend_len, {8'h00, b});
                    pend_len = '0;
                end
                PH_OFFSET_HIGH:
                begin
                    pend_hi = b;
                    phase = PH_OFFSET_LOW;
                end
                default:
                begin
                    phase = PH_HEADER;
                    expect_match(pend_len, {pend_hi, b});
                    pend_len = '0;
                end
            endcase
        endfunction

        function void check_byte(logic [7:0] data, logic last, logic bad);
            out_item_t exp_item;
            results++;
            if (expected_bytes.size() == 0)
            begin
                $error("result with nothing expected: out_byte %0h last_of_run %0b bad_offset %0b",
                       data, last, bad);
                errors++;
                return;
            end
            exp_item = expected_bytes.pop_front();
            if (exp_item.data !== data)
            begin
                $error("out_byte mismatch: expected %0h actual %0h", exp_item.data, data);
                errors++;
            end
            if (exp_item.last !== last)
            begin
                $error("last_of_run mismatch: expected %0b actual %0b", exp_item.last, last);
                errors++;
            end
            if (exp_item.bad !== bad)
            begin
                $error("bad_offset mismatch: expected %0b actual %0b", exp_item.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lzd_in_if  compressed_if ();
    lzd_out_if decompressed_if ();

    lz77_token_stream_decompressor_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .compressed   (compressed_if),
        .decompressed (decompressed_if)
    );

    lzd_byte_scoreboard sb;

    bit bursty;
    bit hold_req;
    bit hold_done;
    int bytes_sent;

    always #1 clk = ~clk;

    task automatic send_byte(logic [7:0] b);
        if (bursty && $urandom_range(0, 5) == 0)
        begin
            compressed_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        compressed_if.valid   <= 1'b1;
        compressed_if.in_byte <= b;
        do
            @(posedge clk);
        while (!compressed_if.ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_match(bit long_form, int unsigned len, int unsigned offset);
        send_byte((long_form ? MATCH_LONG_BASE : MATCH_SHORT_BASE) | 8'(len));
        if (long_form)
            send_byte(8'(offset >> 8));
        send_byte(8'(offset));
    endtask

    // mostly valid back references, some zero or past the bytes held
    function automatic int unsigned pick_offset(int unsigned max_off);
        int unsigned h;
        int unsigned r;
        h = sb.held;
        r = $urandom_range(0, 99);
        if (r < 6 || h == 0)
            return 0;
        if (r < 12)
            return (h < max_off) ? $urandom_range(h + 1, max_off) : 0;
        if (r < 40)
            return $urandom_range(1, (h < 4) ? h : 4);
        return $urandom_range(1, (h < max_off) ? h : max_off);
    endfunction

    task automatic send_random_token();
        int unsigned r;
        int unsigned len;
        r = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 63) : $urandom_range(0, 8);
        if (r < 45)
            send_byte(8'($urandom_range(0, 127)));
        else if (r < 70)
            send_match(1'b0, len, pick_offset(255));
        else if (r < 94)
            send_match(1'b1, len, pick_offset(65535));
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // result side: check accepted items, then pick next ready
    initial
    begin
        int stall_left;
        int hold_cnt;
        stall_left = 0;
        hold_cnt = 0;
        decompressed_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (decompressed_if.valid === 1'b1 && decompressed_if.ready)
                sb.check_byte(decompressed_if.out_byte, decompressed_if.last_of_run,
                              decompressed_if.bad_offset);
            if (hold_req && !hold_done)
            begin
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES)
                    hold_done = 1'b1;
                decompressed_if.ready <= hold_done;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                decompressed_if.ready <= 1'b0;
            end
            else if (bursty && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                decompressed_if.ready <= 1'b0;
            end
            else
                decompressed_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int next_toggle;
        int unsigned h;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        compressed_if.valid = 1'b0;
        compressed_if.in_byte = 8'h00;
        bursty = 1'b1;
        hold_req = 1'b0;
        hold_done = 1'b0;
        bytes_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: headers at both ends, offset errors, zero length, overlap
        send_match(1'b0, 1, 5);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h2A);
        send_match(1'b0, 0, 0);
        send_match(1'b0, 3, 1);
        send_match(1'b0, 4, 0);
        send_match(1'b0, 2, 200);
        send_match(1'b1, 5, 6);
        send_match(1'b1, 2, 256);
        send_match(1'b1, 0, 16'hFFFF);
        send_match(1'b0, 63, 2);
        send_match(1'b1, 63, 64);

        // random tokens with idling on both sides and one long output hold-off
        next_toggle = bytes_sent + 50;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent >= 60)
                hold_req = 1'b1;
            if (bytes_sent >= next_toggle)
            begin
                bursty = ($urandom_range(0, 3) != 0);
                next_toggle += 50;
            end
            send_random_token();
        end

        // no idling from here: long copies at random offsets within the held history, then random tokens
        bursty = 1'b0;
        for (int i = 0; i < LONG_MATCHES; i++)
        begin
            h = sb.held;
            send_match(1'b1, 63, $urandom_range(1, (h < 65535) ? h : 65535));
        end
        repeat (TAIL_BYTES) send_random_token();
        compressed_if.valid <= 1'b0;

        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (2 * 64) @(posedge clk);

        $display("covered %0d input items and %0d results: %0d literals, %0d copied bytes",
                 sb.inputs, sb.results, sb.literals, sb.copied);
        $display("offset errors %0d, history wrapped %0b, output hold-off done %0b",
                 sb.bad_runs, sb.wrapped, hold_done);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
